[rtl/core/b2sh_pkg.sv]
// Package for the single-block salted BLAKE2s hash core.
// Holds the IV, the message schedule table, shared types and constants.
// Depends on nothing; used by every module of the core.
package b2sh_pkg;

  localparam int unsigned Rounds = 10;

  localparam logic [2:0]  LastSlot  = 3'd7;
  localparam logic [31:0] ParamWord = 32'h01010020;
  localparam logic [31:0] ByteCount = 32'h00000040;
  localparam logic [31:0] FinalMark = 32'hffffffff;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  typedef logic [3:0][31:0] row_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  addr;
    logic [63:0] data;
  } msg_wr_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  function automatic logic [3:0] sigma(logic [3:0] rnd, logic [3:0] step);
    logic [3:0] res;
    res = 4'd0;
    if (rnd < 4'(Rounds)) begin
      res = SIGMA[rnd][step];
    end
    return res;
  endfunction

endpackage

[rtl/core/b2sh_msg_mem.sv]
// Message store of the hash core: eight 64-bit word pairs.
// One write port and one registered read port.
// Depends on b2sh_pkg for the write request type.
module b2sh_msg_mem
  import b2sh_pkg::*;
(
  input  logic        clk_i,
  input  msg_wr_t     wr_i,
  input  logic [2:0]  rd_addr_i,
  output logic [63:0] rd_data_o
);

  logic [63:0] mem [8];
  logic [63:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/b2sh_g_unit.sv]
// Shared mixing unit: one half of the BLAKE2s G function per cycle.
// The second half uses the 8 and 7 rotations instead of 16 and 12.
// Depends on b2sh_pkg for the quad type.
module b2sh_g_unit
  import b2sh_pkg::*;
(
  input  quad_t       in_i,
  input  logic [31:0] msg_i,
  input  logic        second_i,
  output quad_t       out_o
);

  logic [31:0] a_n;
  logic [31:0] dx;
  logic [31:0] d_n;
  logic [31:0] c_n;
  logic [31:0] bx;
  logic [31:0] b_n;

  always_comb begin
    a_n = in_i.a + in_i.b + msg_i;
    dx  = in_i.d ^ a_n;
    d_n = second_i ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    c_n = in_i.c + d_n;
    bx  = in_i.b ^ c_n;
    b_n = second_i ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
    out_o = '{a: a_n, b: b_n, c: c_n, d: d_n};
  end

endmodule

[rtl/core/blake2s_salted_block_hash.sv]
// Top level of the single-block salted BLAKE2s-256 hash core.
// Holds the sequencer, the work vector and the salt registers.
// Depends on b2sh_pkg, b2sh_msg_mem and b2sh_g_unit.
//
// An item is a 64-bit message word pair with its slot, taken when start is
// high and busy is low. Slots 0 to 6 are only stored. Slot 7 is stored and
// starts hashing: a read prefetch state, then the run state in which the
// single G half-step unit runs (ten rounds, eight G functions per round,
// two halves each), a state to form the digest and an output state in
// which the four digest pairs leave, one per cycle, marked by result_valid_o,
// the fourth with last_digest_o. A hashing item keeps busy high until its
// last digest pair has left.
// The message store has one read port, which sets the one word per cycle.
// Salt writes on the configuration port are taken at any edge with cfg_we_i
// and must happen while busy is low. The receiver cannot stall; each result
// is valid for one cycle only. Reset clears the sequencer and the salt; the
// message store holds no defined value until its slots are written.
module blake2s_salted_block_hash
  import b2sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] message_pair_i,
  input  logic [2:0]  word_slot_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [63:0] digest_pair_o,
  output logic [1:0]  digest_index_o,
  output logic        last_digest_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREF = 5'b00010,
    ST_RUN  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [3:0]       step_q, step_d;
  logic [3:0]       round_q, round_d;
  logic [1:0]       out_cnt_q, out_cnt_d;
  logic [63:0]      salt_low_q, salt_high_q;
  row_t             row_q [4];
  row_t             row_d [4];
  logic [7:0][31:0] digest_q, digest_d;
  logic             sel_q;
  logic [3:0]       rd_word;
  logic [3:0]       step_n;
  logic [3:0]       round_n;
  logic [63:0]      rd_data;
  logic [31:0]      msg_word;
  logic [31:0]      salt_w [4];
  logic [31:0]      h_w [8];
  logic [1:0]       amt [4];
  quad_t            g_in, g_out;
  msg_wr_t          mem_wr;
  logic             accept;

  function automatic row_t rot_row(row_t r, logic [1:0] n);
    row_t       res;
    logic [1:0] idx;
    for (int i = 0; i < 4; i++) begin
      idx    = 2'(i) + n;
      res[i] = r[idx];
    end
    return res;
  endfunction

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign mem_wr = '{en: accept, addr: word_slot_i, data: message_pair_i};

  assign step_n  = step_q + 4'd1;
  assign round_n = (step_q == 4'd15) ? round_q + 4'd1 : round_q;
  assign rd_word = (state_q == ST_PREF) ? sigma(4'd0, 4'd0) : sigma(round_n, step_n);

  b2sh_msg_mem u_msg_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (rd_word[3:1]),
    .rd_data_o (rd_data)
  );

  assign msg_word = sel_q ? rd_data[63:32] : rd_data[31:0];
  assign g_in     = '{a: row_q[0][0], b: row_q[1][0], c: row_q[2][0], d: row_q[3][0]};

  b2sh_g_unit u_g_unit (
    .in_i     (g_in),
    .msg_i    (msg_word),
    .second_i (step_q[0]),
    .out_o    (g_out)
  );

  assign salt_w[0] = salt_low_q[31:0];
  assign salt_w[1] = salt_low_q[63:32];
  assign salt_w[2] = salt_high_q[31:0];
  assign salt_w[3] = salt_high_q[63:32];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_w[i] = IV[i];
    end
    h_w[0] = IV[0] ^ ParamWord;
    for (int i = 0; i < 4; i++) begin
      h_w[i + 4] = IV[i + 4] ^ salt_w[i];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (step_q == 4'd7) begin
        amt[k] = 2'(k + 1);
      end else if (step_q == 4'd15) begin
        amt[k] = 2'(1 - k);
      end else begin
        amt[k] = 2'd1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    round_d   = round_q;
    out_cnt_d = out_cnt_q;
    digest_d  = digest_q;
    for (int k = 0; k < 4; k++) begin
      row_d[k] = row_q[k];
    end
    case (state_q)
      ST_IDLE: begin
        if (accept && (word_slot_i == LastSlot)) begin
          for (int i = 0; i < 4; i++) begin
            row_d[0][i] = h_w[i];
            row_d[1][i] = h_w[i + 4];
            row_d[2][i] = IV[i];
            row_d[3][i] = IV[i + 4];
          end
          row_d[3][0] = IV[4] ^ ByteCount;
          row_d[3][2] = IV[6] ^ FinalMark;
          step_d  = 4'd0;
          round_d = 4'd0;
          state_d = ST_PREF;
        end
      end
      ST_PREF: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        row_d[0][0] = g_out.a;
        row_d[1][0] = g_out.b;
        row_d[2][0] = g_out.c;
        row_d[3][0] = g_out.d;
        if (step_q[0]) begin
          for (int k = 0; k < 4; k++) begin
            row_d[k] = rot_row(row_d[k], amt[k]);
          end
        end
        step_d  = step_n;
        round_d = round_n;
        if ((step_q == 4'd15) && (round_q == 4'(Rounds - 1))) begin
          round_d = 4'd0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < 4; i++) begin
          digest_d[i]     = h_w[i] ^ row_q[0][i] ^ row_q[2][i];
          digest_d[i + 4] = h_w[i + 4] ^ row_q[1][i] ^ row_q[3][i];
        end
        out_cnt_d = 2'd0;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        digest_d  = {64'd0, digest_q[7:2]};
        out_cnt_d = out_cnt_q + 2'd1;
        if (out_cnt_q == 2'd3) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 4'd0;
      round_q     <= 4'd0;
      out_cnt_q   <= 2'd0;
      salt_low_q  <= 64'd0;
      salt_high_q <= 64'd0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      round_q   <= round_d;
      out_cnt_q <= out_cnt_d;
      if (cfg_we_i) begin
        if (cfg_index_i) begin
          salt_high_q <= cfg_data_i;
        end else begin
          salt_low_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      row_q[k] <= row_d[k];
    end
    digest_q <= digest_d;
    sel_q    <= rd_word[0];
  end

  assign result_valid_o = (state_q == ST_OUT);
  assign digest_pair_o  = {digest_q[1], digest_q[0]};
  assign digest_index_o = out_cnt_q;
  assign last_digest_o  = (out_cnt_q == 2'd3);

endmodule

[test/blake2s_salted_block_hash_test.sv]
`timescale 1ns / 1ps
// Testbench for blake2s_salted_block_hash: feeds message word pairs and salts, and checks
// every digest pair against a BLAKE2s single-block predictor that lives in this file.
// Depends on b2sh_pkg and the blake2s_salted_block_hash RTL.
module blake2s_salted_block_hash_test
  import b2sh_pkg::*;
();

  localparam logic SALT_LOW_REG  = 1'b0;
  localparam logic SALT_HIGH_REG = 1'b1;

  localparam logic [31:0] PARAM_BLOCK = 32'h01010020;
  localparam logic [31:0] BLOCK_BYTES = 32'h00000040;
  localparam logic [31:0] LAST_FLAG   = 32'hffffffff;

  localparam int RANDOM_ITEMS = 198;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_WAIT_LIMIT = 2000;

  localparam logic [31:0] BLAKE_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Message schedule, one round per entry; nibble i selects the word for step i.
  localparam logic [63:0] MSG_ORDER [10] = '{
    64'hfedcba9876543210, 64'h357b20c16df984ae, 64'h491763eadf250c8b,
    64'h8f04a562ebcd1397, 64'hd386cb1efa427509, 64'h91ef57d438b0a6c2,
    64'hb8293670a4def15c, 64'ha2684f05931ce7bd, 64'h5a417d2c803b9ef6,
    64'h0dc3e9bf5167482a
  };

  typedef logic [7:0][31:0] chain_t;

  typedef struct packed {
    logic [63:0] pair;
    logic [1:0]  index;
    logic        last;
  } digest_exp_t;

  typedef enum logic {STEP_SALT, STEP_WORD} step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    logic [2:0]  slot;
    logic [63:0] lo;
    logic [63:0] hi;
  } plan_row_t;

  localparam int PLAN_ROWS = 26;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{STEP_SALT, 3'd0, 64'h0, 64'h0},
    '{STEP_WORD, 3'd0, 64'h0, 64'h0},
    '{STEP_WORD, 3'd1, 64'h0, 64'h0},
    '{STEP_WORD, 3'd2, 64'h0, 64'h0},
    '{STEP_WORD, 3'd3, 64'h0, 64'h0},
    '{STEP_WORD, 3'd4, 64'h0, 64'h0},
    '{STEP_WORD, 3'd5, 64'h0, 64'h0},
    '{STEP_WORD, 3'd6, 64'h0, 64'h0},
    '{STEP_WORD, 3'd7, 64'h0, 64'h0},
    '{STEP_SALT, 3'd0, 64'hffffffffffffffff, 64'hffffffffffffffff},
    '{STEP_WORD, 3'd0, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd1, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd2, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd3, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd4, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd5, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd6, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd7, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd7, 64'hffffffffffffffff, 64'h0},
    '{STEP_WORD, 3'd3, 64'h0123456789abcdef, 64'h0},
    '{STEP_WORD, 3'd7, 64'h8000000000000001, 64'h0},
    '{STEP_SALT, 3'd0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa},
    '{STEP_WORD, 3'd7, 64'h00000000ffffffff, 64'h0},
    '{STEP_WORD, 3'd0, 64'hffffffff00000000, 64'h0},
    '{STEP_SALT, 3'd0, 64'h0, 64'hffffffffffffffff},
    '{STEP_WORD, 3'd7, 64'hfedcba9876543210, 64'h0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] message_pair_i;
  logic [2:0]  word_slot_i;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        result_valid_o;
  logic [63:0] digest_pair_o;
  logic [1:0]  digest_index_o;
  logic        last_digest_o;

  logic [31:0] msg_words [16];
  logic [63:0] salt_lo_q;
  logic [63:0] salt_hi_q;
  digest_exp_t digest_q [$];
  digest_exp_t next_digest;

  int error_count = 0;
  int items_sent = 0;
  int hashes_run = 0;
  int pairs_checked = 0;
  int salt_writes = 0;
  int burst_left = 0;

  blake2s_salted_block_hash uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .message_pair_i (message_pair_i),
    .word_slot_i    (word_slot_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .digest_pair_o  (digest_pair_o),
    .digest_index_o (digest_index_o),
    .last_digest_o  (last_digest_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] rotr32(input logic [31:0] w, input int n);
    return (w >> n) | (w << (32 - n));
  endfunction

  function automatic chain_t blake_digest();
    chain_t h;
    logic [31:0] v [16];
    logic [31:0] a, b, c, d, x, y;
    int ia, ib, ic, id, q;
    for (int i = 0; i < 8; i++) begin
      h[i] = BLAKE_IV[i];
    end
    h[0] ^= PARAM_BLOCK;
    h[4] ^= salt_lo_q[31:0];
    h[5] ^= salt_lo_q[63:32];
    h[6] ^= salt_hi_q[31:0];
    h[7] ^= salt_hi_q[63:32];
    for (int i = 0; i < 8; i++) begin
      v[i] = h[i];
      v[i + 8] = BLAKE_IV[i];
    end
    v[12] ^= BLOCK_BYTES;
    v[14] ^= LAST_FLAG;
    for (int r = 0; r < 10; r++) begin
      for (int u = 0; u < 8; u++) begin
        if (u < 4) begin
          ia = u;
          ib = u + 4;
          ic = u + 8;
          id = u + 12;
        end else begin
          q = u - 4;
          ia = q;
          ib = 4 + ((q + 1) % 4);
          ic = 8 + ((q + 2) % 4);
          id = 12 + ((q + 3) % 4);
        end
        x = msg_words[MSG_ORDER[r][8 * u +: 4]];
        y = msg_words[MSG_ORDER[r][8 * u + 4 +: 4]];
        a = v[ia];
        b = v[ib];
        c = v[ic];
        d = v[id];
        a = a + b + x;
        d = rotr32(d ^ a, 16);
        c = c + d;
        b = rotr32(b ^ c, 12);
        a = a + b + y;
        d = rotr32(d ^ a, 8);
        c = c + d;
        b = rotr32(b ^ c, 7);
        v[ia] = a;
        v[ib] = b;
        v[ic] = c;
        v[id] = d;
      end
    end
    for (int i = 0; i < 8; i++) begin
      h[i] = h[i] ^ v[i] ^ v[i + 8];
    end
    return h;
  endfunction

  // Stores an accepted word pair and, on the last slot, queues the four digest pairs.
  task automatic absorb_word(input logic [2:0] slot, input logic [63:0] pair);
    chain_t h;
    digest_exp_t e;
    msg_words[2 * slot] = pair[31:0];
    msg_words[2 * slot + 1] = pair[63:32];
    if (slot == LastSlot) begin
      h = blake_digest();
      for (int k = 0; k < 4; k++) begin
        e.pair = {h[2 * k + 1], h[2 * k]};
        e.index = 2'(k);
        e.last = (k == 3);
        digest_q.push_back(e);
      end
      hashes_run++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest pair with none pending", digest_pair_o, 64'h0);
      end else begin
        next_digest = digest_q.pop_front();
        if (digest_pair_o !== next_digest.pair) begin
          report_mismatch("digest_pair", digest_pair_o, next_digest.pair);
        end
        if (digest_index_o !== next_digest.index) begin
          report_mismatch("digest_index", 64'(digest_index_o), 64'(next_digest.index));
        end
        if (last_digest_o !== next_digest.last) begin
          report_mismatch("last_digest", 64'(last_digest_o), 64'(next_digest.last));
        end
        pairs_checked++;
      end
    end
  end

  task automatic send_word(input logic [2:0] slot, input logic [63:0] pair);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    start <= 1'b1;
    word_slot_i <= slot;
    message_pair_i <= pair;
    do @(posedge clk_i); while (busy);
    absorb_word(slot, pair);
    items_sent++;
  endtask

  // Lets the block go idle: all digest pairs out, busy low, then a short settle.
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (digest_q.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_salts(input logic [63:0] lo, input logic [63:0] hi);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= SALT_LOW_REG;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_index_i <= SALT_HIGH_REG;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    salt_lo_q = lo;
    salt_hi_q = hi;
    salt_writes++;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return 64'hffffffffffffffff;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int rand_items;
    int mode;
    int count;
    int j;
    logic [2:0] order [7];
    logic [2:0] tmp;
    int waited;
    digest_exp_t lost;

    rst_ni = 1'b0;
    start = 1'b0;
    message_pair_i = '0;
    word_slot_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = SALT_LOW_REG;
    cfg_data_i = '0;
    salt_lo_q = '0;
    salt_hi_q = '0;
    rand_items = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (DIRECTED_PLAN[i].kind == STEP_SALT) begin
        write_salts(DIRECTED_PLAN[i].lo, DIRECTED_PLAN[i].hi);
      end else begin
        send_word(DIRECTED_PLAN[i].slot, DIRECTED_PLAN[i].lo);
      end
    end

    // Every slot is written by now, so any slot order is legal from here on.
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: write_salts(64'h0, 64'h0);
          1: write_salts(64'hffffffffffffffff, 64'hffffffffffffffff);
          default: write_salts(pick_value(), pick_value());
        endcase
      end
      mode = $urandom_range(0, 9);
      if (mode <= 6) begin
        for (int i = 0; i < 7; i++) begin
          order[i] = 3'(i);
        end
        if (mode >= 4) begin
          for (int i = 6; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
        end
        for (int i = 0; i < 7; i++) begin
          send_word(order[i], pick_value());
        end
        send_word(LastSlot, pick_value());
        rand_items += 8;
      end else if (mode == 7) begin
        count = $urandom_range(1, 3);
        for (int i = 0; i < count; i++) begin
          send_word(3'($urandom_range(0, 6)), pick_value());
        end
        send_word(LastSlot, pick_value());
        rand_items += count + 1;
      end else if (mode == 8) begin
        send_word(LastSlot, pick_value());
        rand_items += 1;
      end else begin
        count = $urandom_range(1, 4);
        for (int i = 0; i < count; i++) begin
          send_word(3'($urandom_range(0, 7)), pick_value());
        end
        rand_items += count;
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    waited = 0;
    while (digest_q.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (digest_q.size() != 0) begin
      lost = digest_q.pop_front();
      report_mismatch("digest pair never seen", 64'h0, lost.pair);
    end

    $display("Sent %0d word pairs, ran %0d hashes under %0d salt settings.",
             items_sent, hashes_run, salt_writes);
    $display("Checked %0d digest pairs, %0d mismatches.", pairs_checked, error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/b2sh_pkg.sv
rtl/core/b2sh_msg_mem.sv
rtl/core/b2sh_g_unit.sv
rtl/core/blake2s_salted_block_hash.sv
test/blake2s_salted_block_hash_test.sv
